// ----- src/brl_pkg.sv -----
package brl_pkg;

  localparam int COORD_HALF_SPAN = 32;
  localparam int MAP_SIZE_MAX    = 64;

  localparam int COORD_W = $clog2(2 * COORD_HALF_SPAN);
  localparam int DELTA_W = COORD_W;
  localparam int ERR_W   = COORD_W + 3;
  localparam int CFG_W   = 7;
  localparam int CIDX_W  = 2;
  localparam int COLOR_W = 24;
  localparam int PX_W    = 7;
  localparam int PY_W    = 8;

  localparam logic [CIDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_END  = 3'b010,
    ST_WALK = 3'b100
  } seq_state_t;

  typedef struct packed {
    logic load;
    logic adv;
    logic sel_end;
  } step_cmd_t;

  typedef struct packed {
    logic last;
  } step_stat_t;

endpackage

// ----- src/brl_step.sv -----
module brl_step (
  input  logic                              clk,
  input  brl_pkg::step_cmd_t                cmd,
  input  logic signed [brl_pkg::COORD_W-1:0] in_sx,
  input  logic signed [brl_pkg::COORD_W-1:0] in_sy,
  input  logic signed [brl_pkg::COORD_W-1:0] in_ex,
  input  logic signed [brl_pkg::COORD_W-1:0] in_ey,
  output logic signed [brl_pkg::COORD_W-1:0] pt_x,
  output logic signed [brl_pkg::COORD_W-1:0] pt_y,
  output brl_pkg::step_stat_t               stat
);
  import brl_pkg::*;

  logic signed [COORD_W-1:0] x_r, y_r, ex_r, ey_r;
  logic [DELTA_W-1:0]        dx_r, dy_r, steps_r, n_r;
  logic                      stx_neg_r, sty_neg_r;
  logic signed [ERR_W-1:0]   err_r, err_nxt;

  logic signed [COORD_W:0]   diff_x, diff_y;
  logic [DELTA_W-1:0]        dx_in, dy_in;
  logic signed [ERR_W:0]     e2;
  logic signed [ERR_W:0]     neg_dy, pos_dx;
  logic                      mv_x, mv_y;

  assign diff_x = {in_ex[COORD_W-1], in_ex} - {in_sx[COORD_W-1], in_sx};
  assign diff_y = {in_ey[COORD_W-1], in_ey} - {in_sy[COORD_W-1], in_sy};
  assign dx_in  = diff_x[COORD_W] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
  assign dy_in  = diff_y[COORD_W] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);

  assign e2     = {err_r, 1'b0};
  assign neg_dy = -$signed({{(ERR_W+1-DELTA_W){1'b0}}, dy_r});
  assign pos_dx = $signed({{(ERR_W+1-DELTA_W){1'b0}}, dx_r});
  assign mv_x   = e2 > neg_dy;
  assign mv_y   = e2 < pos_dx;

  always_comb begin
    err_nxt = err_r;
    if (mv_x) begin
      err_nxt = err_nxt - $signed({{(ERR_W-DELTA_W){1'b0}}, dy_r});
    end
    if (mv_y) begin
      err_nxt = err_nxt + $signed({{(ERR_W-DELTA_W){1'b0}}, dx_r});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r       <= in_sx;
      y_r       <= in_sy;
      ex_r      <= in_ex;
      ey_r      <= in_ey;
      dx_r      <= dx_in;
      dy_r      <= dy_in;
      stx_neg_r <= !(in_sx < in_ex);
      sty_neg_r <= !(in_sy < in_ey);
      err_r     <= $signed({{(ERR_W-DELTA_W){1'b0}}, dx_in})
                 - $signed({{(ERR_W-DELTA_W){1'b0}}, dy_in});
      steps_r   <= (dx_in > dy_in) ? dx_in : dy_in;
      n_r       <= DELTA_W'(1);
    end else if (cmd.adv) begin
      err_r <= err_nxt;
      n_r   <= n_r + DELTA_W'(1);
      if (mv_x) begin
        x_r <= stx_neg_r ? x_r - COORD_W'(1) : x_r + COORD_W'(1);
      end
      if (mv_y) begin
        y_r <= sty_neg_r ? y_r - COORD_W'(1) : y_r + COORD_W'(1);
      end
    end
  end

  assign pt_x      = cmd.sel_end ? ex_r : x_r;
  assign pt_y      = cmd.sel_end ? ey_r : y_r;
  assign stat.last = cmd.sel_end ? (steps_r == '0) : (n_r == steps_r);

endmodule

// ----- src/brl_map.sv -----
module brl_map (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               emit,
  input  logic signed [brl_pkg::COORD_W-1:0] pt_x,
  input  logic signed [brl_pkg::COORD_W-1:0] pt_y,
  input  logic                               pt_last,
  input  logic [brl_pkg::COLOR_W-1:0]        color,
  input  logic [brl_pkg::CFG_W-1:0]          map_w,
  input  logic [brl_pkg::CFG_W-1:0]          map_h,
  output logic                               out_strobe,
  output logic signed [brl_pkg::PX_W-1:0]    out_pixel_x,
  output logic signed [brl_pkg::PY_W-1:0]    out_pixel_y,
  output logic                               out_inside_map,
  output logic [brl_pkg::COLOR_W-1:0]        out_pixel_color,
  output logic                               out_last_point
);
  import brl_pkg::*;

  logic [CFG_W-1:0]       w_c, h_c;
  logic signed [PY_W-1:0] x_full, y_full;
  logic                   in_bounds;

  logic                   strobe_r;
  logic signed [PX_W-1:0] px_r;
  logic signed [PY_W-1:0] py_r;
  logic                   inside_r, last_r;
  logic [COLOR_W-1:0]     color_r;

  assign w_c = (map_w > CFG_W'(MAP_SIZE_MAX)) ? CFG_W'(MAP_SIZE_MAX) : map_w;
  assign h_c = (map_h > CFG_W'(MAP_SIZE_MAX)) ? CFG_W'(MAP_SIZE_MAX) : map_h;

  assign x_full = $signed({2'b00, w_c[CFG_W-1:1]})
                + $signed({{(PY_W-COORD_W){pt_x[COORD_W-1]}}, pt_x});
  assign y_full = $signed({2'b00, h_c[CFG_W-1:1]})
                - $signed({{(PY_W-COORD_W){pt_y[COORD_W-1]}}, pt_y});

  assign in_bounds = !x_full[PY_W-1] && (x_full[CFG_W-1:0] < w_c)
                  && !y_full[PY_W-1] && (y_full[CFG_W-1:0] < h_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      px_r     <= x_full[PX_W-1:0];
      py_r     <= y_full;
      inside_r <= in_bounds;
      last_r   <= pt_last;
      color_r  <= color;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_inside_map  = inside_r;
  assign out_pixel_color = color_r;
  assign out_last_point  = last_r;

endmodule

// ----- src/bresenham_line_rasterizer_unit.sv -----
// Channel   Handshake                  Payload
// input     start in, busy out         in_start_x/y, in_end_x/y, in_line_color
// result    out_strobe out             out_pixel_x/y, out_inside_map,
//                                      out_pixel_color, out_last_point
// config    cfg_we in                  cfg_index, cfg_wdata
//
// A line of L major-axis steps emits L+1 points, one per cycle from the shared step unit.
// The end point is emitted first, from the end state, and shown through the output register.
// Busy stays high from the accepting edge until the last point has been emitted, and the next
// line is accepted only in the idle cycle that follows.
// Reset is synchronous and active low; it returns the sequencer to idle and the map to 64x64.
// The receiver cannot stall: each point is shown for exactly one cycle.
module bresenham_line_rasterizer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [brl_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [brl_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [brl_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [brl_pkg::COORD_W-1:0] in_end_y,
  input  logic [brl_pkg::COLOR_W-1:0]        in_line_color,
  input  logic                               cfg_we,
  input  logic [brl_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [brl_pkg::CFG_W-1:0]          cfg_wdata,
  output logic                               out_strobe,
  output logic signed [brl_pkg::PX_W-1:0]    out_pixel_x,
  output logic signed [brl_pkg::PY_W-1:0]    out_pixel_y,
  output logic                               out_inside_map,
  output logic [brl_pkg::COLOR_W-1:0]        out_pixel_color,
  output logic                               out_last_point
);
  import brl_pkg::*;

  seq_state_t                state_r, state_nxt;
  logic [CFG_W-1:0]          map_w_r, map_h_r;
  logic [COLOR_W-1:0]        color_r;
  step_cmd_t                 cmd;
  step_stat_t                stat;
  logic signed [COORD_W-1:0] pt_x, pt_y;
  logic                      emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r <= CFG_W'(MAP_SIZE_MAX);
      map_h_r <= CFG_W'(MAP_SIZE_MAX);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_w_r <= cfg_wdata;
        REG_MAP_HEIGHT: map_h_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.adv     = 1'b0;
    cmd.sel_end = 1'b0;
    emit        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        cmd.sel_end = 1'b1;
        emit        = 1'b1;
        state_nxt   = stat.last ? ST_IDLE : ST_WALK;
      end
      ST_WALK: begin
        cmd.adv = 1'b1;
        emit    = 1'b1;
        if (stat.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      color_r <= in_line_color;
    end
  end

  assign busy = (state_r != ST_IDLE);

  brl_step u_step (
    .clk   (clk),
    .cmd   (cmd),
    .in_sx (in_start_x),
    .in_sy (in_start_y),
    .in_ex (in_end_x),
    .in_ey (in_end_y),
    .pt_x  (pt_x),
    .pt_y  (pt_y),
    .stat  (stat)
  );

  brl_map u_map (
    .clk             (clk),
    .rst_n           (rst_n),
    .emit            (emit),
    .pt_x            (pt_x),
    .pt_y            (pt_y),
    .pt_last         (stat.last),
    .color           (color_r),
    .map_w           (map_w_r),
    .map_h           (map_h_r),
    .out_strobe      (out_strobe),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_inside_map  (out_inside_map),
    .out_pixel_color (out_pixel_color),
    .out_last_point  (out_last_point)
  );

endmodule

// ----- src/brl_checker.sv -----
module brl_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_strobe,
  input logic signed [brl_pkg::PX_W-1:0]    out_pixel_x,
  input logic signed [brl_pkg::PY_W-1:0]    out_pixel_y,
  input logic                               out_inside_map,
  input logic                               out_last_point
);
  import brl_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_strobe)
    else $error("block not quiet after reset");

  a_first_point: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_strobe)
    else $error("end point not emitted two cycles after accept");

  a_points_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_point |=> out_strobe)
    else $error("gap in the points of a line");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_point |-> !busy)
    else $error("still busy when the last point is shown");

  a_inside_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_inside_map |-> !out_pixel_x[PX_W-1] && !out_pixel_y[PY_W-1])
    else $error("negative coordinate flagged inside the map");

endmodule

bind bresenham_line_rasterizer_unit brl_checker u_brl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_pixel_x    (out_pixel_x),
  .out_pixel_y    (out_pixel_y),
  .out_inside_map (out_inside_map),
  .out_last_point (out_last_point)
);
